// ===== hw/rtl/ebe_pkg.sv =====
`timescale 1ns / 1ps

package ebe_pkg;

   localparam int QueueDepthDefault = 2;

   localparam logic [7:0] OP_END    = 8'h00;
   localparam logic [7:0] OP_WAIT   = 8'h01;
   localparam logic [7:0] OP_REG    = 8'h10;
   localparam logic [7:0] OP_PLAY_A = 8'h20;
   localparam logic [7:0] OP_STOP_A = 8'h21;
   localparam logic [7:0] OP_PLAY_B = 8'h22;
   localparam logic [7:0] OP_STOP_B = 8'h23;

   typedef enum logic [2:0] {
      FUNC_REG    = 3'd0,
      FUNC_PLAY_A = 3'd1,
      FUNC_STOP_A = 3'd2,
      FUNC_PLAY_B = 3'd3,
      FUNC_STOP_B = 3'd4,
      FUNC_FINISH = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ORDER    = 2'd1,
      ST_DELTA_N  = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic {
      CSR_CAPTURE = 1'b0,
      CSR_TAIL    = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_CALC,
      FE_PUSH
   } fe_state_type;

   typedef enum logic [2:0] {
      BE_IDLE,
      BE_OP_A,
      BE_ULEB_A,
      BE_OP_B,
      BE_ULEB_B,
      BE_CMD,
      BE_ERR
   } be_state_type;

   // One queued job: an error word, or up to two waits followed by a command.
   typedef struct packed {
      logic        err;
      status_type  status;
      logic [63:0] wait_a;
      logic [63:0] wait_b;
      logic [3:0]  cmd_len;
      logic [63:0] cmd_bytes;
   } job_type;

endpackage

// ===== hw/rtl/ebe_front.sv =====
`timescale 1ns / 1ps

module ebe_front import ebe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [63:0] req_event_cycle,
   input  logic [15:0] req_target_id,
   input  logic [7:0]  req_reg_data,
   input  logic [15:0] req_delta_n,
   input  logic [7:0]  req_level,
   input  logic [7:0]  req_pan,
   input  logic [7:0]  req_play_flags,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [63:0] csr_data,
   output logic        push,
   output job_type     push_job,
   input  logic        queue_full
);

   fe_state_type state_ff, state_in;
   logic [2:0]  func_ff;
   logic [63:0] cyc_ff;
   logic [15:0] tid_ff;
   logic [7:0]  data_ff;
   logic [15:0] dn_ff;
   logic [7:0]  level_ff;
   logic [7:0]  pan_ff;
   logic [7:0]  flags_ff;
   logic [63:0] cursor_ff, cursor_in;
   logic [63:0] capture_ff;
   logic [63:0] tail_ff;
   logic [63:0] delta_ff;
   logic        borrow_ff;
   logic [63:0] end_ff;
   logic [64:0] diff;
   logic [64:0] total;
   logic [63:0] pad;
   logic        accept;

   assign accept = req_valid && !req_stall;
   assign diff   = {1'b0, cyc_ff} - {1'b0, cursor_ff};
   assign total  = {1'b0, end_ff} + {1'b0, tail_ff};
   assign pad    = end_ff - cursor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FE_IDLE;
         cursor_ff  <= '0;
         capture_ff <= '0;
         tail_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         if (csr_write) begin
            unique case (csr_index_type'(csr_index))
               CSR_CAPTURE: capture_ff <= csr_data;
               CSR_TAIL:    tail_ff    <= csr_data;
               default:     ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         cyc_ff   <= req_event_cycle;
         tid_ff   <= req_target_id;
         data_ff  <= req_reg_data;
         dn_ff    <= req_delta_n;
         level_ff <= req_level;
         pan_ff   <= req_pan;
         flags_ff <= req_play_flags;
      end
      if (state_ff == FE_CALC) begin
         delta_ff  <= diff[63:0];
         borrow_ff <= diff[64];
         end_ff    <= (cursor_ff > capture_ff) ? cursor_ff : capture_ff;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cursor_in = cursor_ff;
      req_stall = 1'b1;
      push      = 1'b0;
      push_job  = '0;
      unique case (state_ff)
         FE_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = FE_CALC;
            end
         end
         FE_CALC: begin
            state_in = (func_ff > 3'(FUNC_FINISH)) ? FE_IDLE : FE_PUSH;
         end
         FE_PUSH: begin
            if (func_ff == 3'(FUNC_FINISH)) begin
               if (total[64]) begin
                  push_job.err    = 1'b1;
                  push_job.status = ST_OVERFLOW;
               end else begin
                  push_job.wait_a    = pad;
                  push_job.wait_b    = tail_ff;
                  push_job.cmd_len   = 4'd1;
                  push_job.cmd_bytes = {OP_END, 56'd0};
               end
            end else if (borrow_ff) begin
               push_job.err    = 1'b1;
               push_job.status = ST_ORDER;
            end else if (func_ff == 3'(FUNC_PLAY_B) && dn_ff == 16'd0) begin
               push_job.err    = 1'b1;
               push_job.status = ST_DELTA_N;
            end else begin
               push_job.wait_a = delta_ff;
               unique case (func_type'(func_ff))
                  FUNC_REG: begin
                     push_job.cmd_len   = 4'd4;
                     push_job.cmd_bytes = {OP_REG, tid_ff, data_ff, 32'd0};
                  end
                  FUNC_PLAY_A: begin
                     push_job.cmd_len   = 4'd5;
                     push_job.cmd_bytes = {OP_PLAY_A, tid_ff, level_ff, pan_ff, 24'd0};
                  end
                  FUNC_STOP_A: begin
                     push_job.cmd_len   = 4'd1;
                     push_job.cmd_bytes = {OP_STOP_A, 56'd0};
                  end
                  FUNC_PLAY_B: begin
                     push_job.cmd_len   = 4'd8;
                     push_job.cmd_bytes = {OP_PLAY_B, tid_ff, dn_ff, level_ff, pan_ff,
                                           flags_ff};
                  end
                  default: begin
                     push_job.cmd_len   = 4'd1;
                     push_job.cmd_bytes = {OP_STOP_B, 56'd0};
                  end
               endcase
            end
            if (!queue_full) begin
               push     = 1'b1;
               state_in = FE_IDLE;
               if (func_ff == 3'(FUNC_FINISH)) begin
                  if (!total[64]) begin
                     cursor_in = '0;
                  end
               end else if (!borrow_ff && !(func_ff == 3'(FUNC_PLAY_B) && dn_ff == 16'd0)) begin
                  cursor_in = cyc_ff;
               end
            end
         end
         default: state_in = FE_IDLE;
      endcase
   end

endmodule

// ===== hw/rtl/ebe_queue.sv =====
`timescale 1ns / 1ps

module ebe_queue import ebe_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   localparam int PtrWidth = $clog2(QUEUE_DEPTH);

   job_type             slot_ff [QUEUE_DEPTH];
   logic [PtrWidth:0]   wr_ptr_ff;
   logic [PtrWidth:0]   rd_ptr_ff;

   assign empty   = (wr_ptr_ff == rd_ptr_ff);
   assign full    = (wr_ptr_ff[PtrWidth] != rd_ptr_ff[PtrWidth]) &&
                    (wr_ptr_ff[PtrWidth-1:0] == rd_ptr_ff[PtrWidth-1:0]);
   assign pop_job = slot_ff[rd_ptr_ff[PtrWidth-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop && !empty) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff[PtrWidth-1:0]] <= push_job;
      end
   end

endmodule

// ===== hw/rtl/ebe_back.sv =====
`timescale 1ns / 1ps

module ebe_back import ebe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       queue_empty,
   input  job_type    pop_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_end,
   output logic [1:0] rsp_status
);

   be_state_type state_ff, state_in;
   job_type      job_ff;
   logic [63:0]  val_ff, val_in;
   logic [63:0]  cmd_ff, cmd_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic         valid_ff, valid_in;
   logic [7:0]   byte_ff, byte_in;
   logic         end_ff, end_in;
   logic [1:0]   status_ff, status_in;
   logic         out_free;
   logic         val_more;
   logic [7:0]   uleb_byte;

   assign out_free     = !valid_ff || !rsp_stall;
   assign val_more     = |val_ff[63:7];
   assign uleb_byte    = {val_more, val_ff[6:0]};
   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_run_end  = end_ff;
   assign rsp_status   = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= pop_job;
      end
      val_ff    <= val_in;
      cmd_ff    <= cmd_in;
      cnt_ff    <= cnt_in;
      byte_ff   <= byte_in;
      end_ff    <= end_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in  = state_ff;
      val_in    = val_ff;
      cmd_in    = cmd_ff;
      cnt_in    = cnt_ff;
      valid_in  = valid_ff && rsp_stall;
      byte_in   = byte_ff;
      end_in    = end_ff;
      status_in = status_ff;
      pop       = 1'b0;
      unique case (state_ff) inside
         BE_IDLE: begin
            if (!queue_empty) begin
               pop    = 1'b1;
               cmd_in = pop_job.cmd_bytes;
               cnt_in = pop_job.cmd_len;
               if (pop_job.err) begin
                  state_in = BE_ERR;
               end else if (pop_job.wait_a != 64'd0) begin
                  state_in = BE_OP_A;
               end else if (pop_job.wait_b != 64'd0) begin
                  state_in = BE_OP_B;
               end else begin
                  state_in = BE_CMD;
               end
            end
         end
         BE_OP_A, BE_OP_B: begin
            if (out_free) begin
               valid_in  = 1'b1;
               byte_in   = OP_WAIT;
               end_in    = 1'b0;
               status_in = ST_OK;
               val_in    = (state_ff == BE_OP_A) ? job_ff.wait_a : job_ff.wait_b;
               state_in  = (state_ff == BE_OP_A) ? BE_ULEB_A : BE_ULEB_B;
            end
         end
         BE_ULEB_A, BE_ULEB_B: begin
            if (out_free) begin
               valid_in  = 1'b1;
               byte_in   = uleb_byte;
               end_in    = 1'b0;
               status_in = ST_OK;
               val_in    = {7'd0, val_ff[63:7]};
               if (!val_more) begin
                  if (state_ff == BE_ULEB_A && job_ff.wait_b != 64'd0) begin
                     state_in = BE_OP_B;
                  end else begin
                     state_in = BE_CMD;
                  end
               end
            end
         end
         BE_CMD: begin
            if (out_free) begin
               valid_in  = 1'b1;
               byte_in   = cmd_ff[63:56];
               end_in    = (cnt_ff == 4'd1);
               status_in = ST_OK;
               cmd_in    = {cmd_ff[55:0], 8'd0};
               cnt_in    = cnt_ff - 4'd1;
               if (cnt_ff == 4'd1) begin
                  state_in = BE_IDLE;
               end
            end
         end
         BE_ERR: begin
            if (out_free) begin
               valid_in  = 1'b1;
               byte_in   = 8'd0;
               end_in    = 1'b1;
               status_in = job_ff.status;
               state_in  = BE_IDLE;
            end
         end
         default: state_in = BE_IDLE;
      endcase
   end

endmodule

// ===== hw/rtl/event_stream_bytecode_encoder_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   func, event_cycle, operand fields
// rsp_      out        rsp_valid/rsp_stall   out_byte, run_end, status
// csr_      in         csr_write             csr_index, csr_data
//
// The front registers a word, works out its delta and pushes the job to a small queue,
// taking no new word until it is idle again; an undefined function code makes no job.
// The back loads a job while idle, then sends one word per cycle unless rsp_ stalls.
// Synchronous reset clears the cursor, both registers, the queue and both controllers.
// A stall on rsp_ fills the queue first and only then holds off req_.

module event_stream_bytecode_encoder_core import ebe_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [63:0] req_event_cycle,
   input  logic [15:0] req_target_id,
   input  logic [7:0]  req_reg_data,
   input  logic [15:0] req_delta_n,
   input  logic [7:0]  req_level,
   input  logic [7:0]  req_pan,
   input  logic [7:0]  req_play_flags,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_end,
   output logic [1:0]  rsp_status,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);

   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    pop;
   job_type pop_job;
   logic    queue_empty;

   ebe_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_event_cycle (req_event_cycle),
      .req_target_id   (req_target_id),
      .req_reg_data    (req_reg_data),
      .req_delta_n     (req_delta_n),
      .req_level       (req_level),
      .req_pan         (req_pan),
      .req_play_flags  (req_play_flags),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .push            (push),
      .push_job        (push_job),
      .queue_full      (queue_full)
   );

   ebe_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   ebe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_empty  (queue_empty),
      .pop_job      (pop_job),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_end  (rsp_run_end),
      .rsp_status   (rsp_status)
   );

endmodule

// ===== tb/stream_checker.sv =====
`timescale 1ns / 1ps

module stream_checker import ebe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [63:0] req_event_cycle,
   input  logic [15:0] req_target_id,
   input  logic [7:0]  req_reg_data,
   input  logic [15:0] req_delta_n,
   input  logic [7:0]  req_level,
   input  logic [7:0]  req_pan,
   input  logic [7:0]  req_play_flags,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_run_end,
   input  logic [1:0]  rsp_status,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [63:0] csr_data,
   output int          words_due,
   output int          failures
);

   typedef struct packed {
      logic [7:0] code;
      logic       last;
      status_type status;
   } stream_word_type;

   stream_word_type stream_due[$];
   logic [63:0] cursor;
   logic [63:0] window_capture;
   logic [63:0] window_tail;
   int failure_count = 0;

   assign failures = failure_count;

   task automatic put_code(input logic [7:0] code);
      stream_word_type w;
      w.code = code;
      w.last = 1'b0;
      w.status = ST_OK;
      stream_due = {stream_due, w};
   endtask

   task automatic put_fault(input status_type status);
      stream_word_type w;
      w.code = 8'h00;
      w.last = 1'b1;
      w.status = status;
      stream_due = {stream_due, w};
   endtask

   // A wait is its opcode followed by the span in ULEB128, low group first.
   task automatic put_wait(input logic [63:0] span);
      logic [63:0] rest;
      logic [7:0]  code;
      rest = span;
      if (rest != 0) begin
         put_code(OP_WAIT);
         do begin
            code = {1'b0, rest[6:0]};
            rest = rest >> 7;
            if (rest != 0) begin
               code[7] = 1'b1;
            end
            put_code(code);
         end while (rest != 0);
      end
   endtask

   task automatic close_run();
      stream_word_type w;
      w = stream_due[stream_due.size() - 1];
      w.last = 1'b1;
      stream_due[stream_due.size() - 1] = w;
   endtask

   task automatic encode_event();
      logic [63:0] stop_at;
      if (req_func == FUNC_FINISH) begin
         stop_at = (cursor > window_capture) ? cursor : window_capture;
         if (window_tail > ~stop_at) begin
            put_fault(ST_OVERFLOW);
         end else begin
            put_wait(stop_at - cursor);
            put_wait(window_tail);
            put_code(OP_END);
            cursor = '0;
            close_run();
         end
      end else if (req_func <= FUNC_STOP_B) begin
         if (req_event_cycle < cursor) begin
            put_fault(ST_ORDER);
         end else if (req_func == FUNC_PLAY_B && req_delta_n == 16'h0000) begin
            put_fault(ST_DELTA_N);
         end else begin
            put_wait(req_event_cycle - cursor);
            cursor = req_event_cycle;
            case (req_func)
               FUNC_REG: begin
                  put_code(OP_REG);
                  put_code(req_target_id[15:8]);
                  put_code(req_target_id[7:0]);
                  put_code(req_reg_data);
               end
               FUNC_PLAY_A: begin
                  put_code(OP_PLAY_A);
                  put_code(req_target_id[15:8]);
                  put_code(req_target_id[7:0]);
                  put_code(req_level);
                  put_code(req_pan);
               end
               FUNC_STOP_A: begin
                  put_code(OP_STOP_A);
               end
               FUNC_PLAY_B: begin
                  put_code(OP_PLAY_B);
                  put_code(req_target_id[15:8]);
                  put_code(req_target_id[7:0]);
                  put_code(req_delta_n[15:8]);
                  put_code(req_delta_n[7:0]);
                  put_code(req_level);
                  put_code(req_pan);
                  put_code(req_play_flags);
               end
               default: begin
                  put_code(OP_STOP_B);
               end
            endcase
            close_run();
         end
      end
   endtask

   always @(posedge clock) begin
      stream_word_type w;
      if (reset) begin
         stream_due.delete();
         cursor = '0;
         window_capture = '0;
         window_tail = '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_CAPTURE: window_capture = csr_data;
               CSR_TAIL: window_tail = csr_data;
            endcase
         end
         if (req_valid && !req_stall) begin
            encode_event();
         end
         if (rsp_valid && !rsp_stall) begin
            if (stream_due.size() == 0) begin
               $error("word with nothing expected: out_byte %h run_end %b status %0d",
                      rsp_out_byte, rsp_run_end, rsp_status);
               failure_count++;
            end else begin
               w = stream_due.pop_front();
               if (rsp_out_byte !== w.code) begin
                  $error("out_byte: expected %h, got %h", w.code, rsp_out_byte);
                  failure_count++;
               end
               if (rsp_run_end !== w.last) begin
                  $error("run_end: expected %b, got %b", w.last, rsp_run_end);
                  failure_count++;
               end
               if (rsp_status !== w.status) begin
                  $error("status: expected %0d, got %0d", w.status, rsp_status);
                  failure_count++;
               end
            end
         end
      end
      words_due <= stream_due.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import ebe_pkg::*;

   localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
   localparam int WatchdogLimit = 2000;
   localparam int HoldCycles = 300;
   localparam int PhaseItems = 43;

   typedef struct {
      logic [2:0]  func;
      logic [63:0] cycle;
      logic [15:0] tid;
      logic [7:0]  data;
      logic [15:0] dn;
      logic [7:0]  level;
      logic [7:0]  pan;
      logic [7:0]  flags;
   } sound_event_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_func;
   logic [63:0] req_event_cycle;
   logic [15:0] req_target_id;
   logic [7:0]  req_reg_data;
   logic [15:0] req_delta_n;
   logic [7:0]  req_level;
   logic [7:0]  req_pan;
   logic [7:0]  req_play_flags;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_end;
   logic [1:0]  rsp_status;
   logic        csr_write;
   logic        csr_index;
   logic [63:0] csr_data;

   int words_due;
   int failures;
   int quiet_cycles = 0;
   bit steady = 1'b0;
   bit hold_output = 1'b0;
   logic [63:0] next_cycle = '0;
   logic [63:0] cfg_capture = '0;
   logic [63:0] cfg_tail = '0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   event_stream_bytecode_encoder_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_event_cycle(req_event_cycle),
      .req_target_id(req_target_id),
      .req_reg_data(req_reg_data),
      .req_delta_n(req_delta_n),
      .req_level(req_level),
      .req_pan(req_pan),
      .req_play_flags(req_play_flags),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_end(rsp_run_end),
      .rsp_status(rsp_status),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   stream_checker stream_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_event_cycle(req_event_cycle),
      .req_target_id(req_target_id),
      .req_reg_data(req_reg_data),
      .req_delta_n(req_delta_n),
      .req_level(req_level),
      .req_pan(req_pan),
      .req_play_flags(req_play_flags),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_end(rsp_run_end),
      .rsp_status(rsp_status),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .words_due(words_due),
      .failures(failures)
   );

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WatchdogLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic sound_event_type event_of(
      input logic [2:0] func, input logic [63:0] cycle, input logic [15:0] tid,
      input logic [7:0] data, input logic [15:0] dn, input logic [7:0] level,
      input logic [7:0] pan, input logic [7:0] flags);
      sound_event_type ev;
      ev.func = func;
      ev.cycle = cycle;
      ev.tid = tid;
      ev.data = data;
      ev.dn = dn;
      ev.level = level;
      ev.pan = pan;
      ev.flags = flags;
      return ev;
   endfunction

   // Mostly in-order events with random operands; a minority of finishes,
   // ignored codes, late events and zero steps.
   function automatic sound_event_type random_event();
      sound_event_type ev;
      logic [63:0] step;
      logic [63:0] jump;
      int pick;
      int size_pick;
      ev = event_of(3'($urandom_range(FUNC_REG, FUNC_STOP_B)), '0, 16'($urandom),
                    8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
      if (ev.dn == 16'h0000) begin
         ev.dn = 16'h0001;
      end
      jump = {$urandom, $urandom};
      size_pick = $urandom_range(0, 99);
      if (size_pick < 30) begin
         step = '0;
      end else if (size_pick < 80) begin
         step = 64'($urandom_range(1, 200));
      end else if (size_pick < 95) begin
         step = 64'($urandom_range(201, 1 << 21));
      end else begin
         step = jump;
      end
      ev.cycle = (next_cycle + step < next_cycle) ? ~64'd0 : next_cycle + step;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         ev.func = FUNC_FINISH;
         ev.cycle = jump;
      end else if (pick < 9) begin
         ev.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
      end else if (pick < 14) begin
         if (next_cycle != 0) begin
            ev.cycle = next_cycle - 64'd1 - (jump % next_cycle);
         end
      end else if (pick < 17) begin
         ev.func = FUNC_PLAY_B;
         ev.dn = 16'h0000;
      end
      return ev;
   endfunction

   task automatic send_event(input sound_event_type ev);
      int gap;
      logic [63:0] reach;
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_func <= ev.func;
      req_event_cycle <= ev.cycle;
      req_target_id <= ev.tid;
      req_reg_data <= ev.data;
      req_delta_n <= ev.dn;
      req_level <= ev.level;
      req_pan <= ev.pan;
      req_play_flags <= ev.flags;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (ev.func == FUNC_FINISH) begin
         reach = (next_cycle > cfg_capture) ? next_cycle : cfg_capture;
         if (cfg_tail <= ~reach) begin
            next_cycle = '0;
         end
      end else if (ev.func <= FUNC_STOP_B && ev.cycle >= next_cycle &&
                   !(ev.func == FUNC_PLAY_B && ev.dn == 16'h0000)) begin
         next_cycle = ev.cycle;
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_due != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_window(input logic [63:0] capture, input logic [63:0] tail);
      csr_write <= 1'b1;
      csr_index <= CSR_CAPTURE;
      csr_data <= capture;
      @(posedge clock);
      csr_index <= CSR_TAIL;
      csr_data <= tail;
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_capture = capture;
      cfg_tail = tail;
   endtask

   initial begin
      int pause;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_output) begin
            pause = HoldCycles;
            hold_output = 1'b0;
         end else if (steady) begin
            pause = 0;
         end else begin
            pause = $urandom_range(0, 9);
         end
         if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= FUNC_REG;
      req_event_cycle <= '0;
      req_target_id <= '0;
      req_reg_data <= '0;
      req_delta_n <= '0;
      req_level <= '0;
      req_pan <= '0;
      req_play_flags <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_CAPTURE;
      csr_data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_event(event_of(FUNC_REG, 64'd0, 16'hffff, 8'hff, 16'h0001, 8'h00, 8'h00, 8'h00));
      send_event(event_of(FUNC_PLAY_A, 64'd1, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'hff,
                          8'h00));
      send_event(event_of(FUNC_STOP_A, 64'd128, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00,
                          8'h00));
      send_event(event_of(FUNC_STOP_B, 64'd256, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00,
                          8'h00));
      send_event(event_of(FUNC_PLAY_B, 64'd256, 16'h8001, 8'h5a, 16'hffff, 8'hff, 8'h00,
                          8'hff));
      send_event(event_of(FUNC_PLAY_B, 64'd300, 16'h1234, 8'h00, 16'h0000, 8'h11, 8'h22,
                          8'h33));
      send_event(event_of(FUNC_REG, 64'd100, 16'h00ff, 8'h01, 16'h0001, 8'h00, 8'h00, 8'h00));
      send_event(event_of(FUNC_PLAY_B, 64'd5, 16'h0f0f, 8'h00, 16'h0000, 8'h00, 8'h00,
                          8'h00));
      send_event(event_of(FUNC_SPARE_LO, 64'd0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00,
                          8'h00));
      send_event(event_of(FUNC_SPARE_HI, ~64'd0, 16'hffff, 8'hff, 16'hffff, 8'hff, 8'hff,
                          8'hff));
      send_event(event_of(FUNC_PLAY_B, 64'd16384, 16'h7ffe, 8'h00, 16'h0001, 8'h80, 8'h01,
                          8'h00));
      send_event(event_of(FUNC_REG, ~64'd0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
      send_event(event_of(FUNC_FINISH, 64'h1234_5678_9abc_def0, 16'hbeef, 8'h77, 16'h0000,
                          8'h44, 8'h55, 8'h66));
      send_event(event_of(FUNC_PLAY_A, 64'd0, 16'hffff, 8'h00, 16'h0000, 8'hff, 8'h00,
                          8'h00));
      settle();
      set_window(~64'd0, 64'd0);
      send_event(event_of(FUNC_FINISH, 64'd0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00,
                          8'h00));
      settle();
      set_window(64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
      send_event(event_of(FUNC_FINISH, ~64'd0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00,
                          8'h00));
      settle();
      set_window(64'd5, ~64'd0);
      send_event(event_of(FUNC_STOP_A, 64'd3, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00,
                          8'h00));
      send_event(event_of(FUNC_FINISH, 64'd0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00,
                          8'h00));
      send_event(event_of(FUNC_FINISH, 64'd0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00,
                          8'h00));
      settle();
      set_window(64'd0, 64'd0);
      send_event(event_of(FUNC_FINISH, 64'd0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00,
                          8'h00));

      for (int phase = 0; phase < 6; phase++) begin
         settle();
         steady = (phase == 0);
         case (phase)
            0: set_window(64'd0, 64'd0);
            1: set_window(64'($urandom_range(0, 3000)), 64'($urandom_range(0, 300)));
            2: set_window(~64'd0, 64'd0);
            3: set_window(64'($urandom_range(1, 100)), ~64'd0);
            4: set_window(64'd200, 64'd50);
            default: set_window(64'd0, {32'h0, $urandom});
         endcase
         // The output is held off for a long stretch so that the input backs up.
         if (phase == 4) begin
            hold_output = 1'b1;
         end
         for (int n = 0; n < PhaseItems; n++) begin
            send_event(random_event());
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (words_due != 0);
      repeat (40) @(posedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/ebe_pkg.sv
hw/rtl/ebe_front.sv
hw/rtl/ebe_queue.sv
hw/rtl/ebe_back.sv
hw/rtl/event_stream_bytecode_encoder_core.sv
tb/stream_checker.sv
tb/testbench.sv
